FILE: hdl/cpga_pkg.sv
// Shared widths, register indexes, angle table and rounding for the aiming pipeline
`default_nettype none
package cpga_pkg;
	localparam int CFG_W = 60;
	localparam int IDX_W = 3;
	localparam int CW = 24;
	localparam int GW = 30;
	localparam int RW = 60;
	localparam int SQ_STEPS = RW / 2;
	localparam int SQW = SQ_STEPS + 1;
	localparam int KW = 58;
	localparam int ZW = 25;
	localparam int AW = 16;
	localparam int LIMIT = 23040;

	localparam logic [IDX_W-1:0] REG_ROT_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROT_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROT_Z = 3'd2;
	localparam logic [IDX_W-1:0] REG_TRANS = 3'd3;
	localparam logic [IDX_W-1:0] REG_BARREL = 3'd4;
	localparam logic [IDX_W-1:0] REG_MIN_D = 3'd5;
	localparam logic [IDX_W-1:0] REG_MAX_D = 3'd6;

	localparam logic signed [ZW-1:0] ATAN_TAB [0:23] = '{
		25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945, 25'sd234379, 25'sd117266,
		25'sd58666, 25'sd29335, 25'sd14668, 25'sd7334, 25'sd3667, 25'sd1833,
		25'sd917, 25'sd458, 25'sd229, 25'sd115, 25'sd57, 25'sd29,
		25'sd14, 25'sd7, 25'sd4, 25'sd2, 25'sd1, 25'sd0
	};

	typedef struct packed {
		logic vld;
		logic in_range;
		logic err;
	} flag_t;

	typedef struct packed {
		flag_t fl;
		logic signed [GW-1:0] gx;
		logic signed [GW-1:0] gy;
		logic signed [GW-1:0] gz;
	} side_t;

	function automatic logic signed [AW-1:0] rnd_sat(input logic signed [ZW:0] v);
		logic signed [ZW:0] a;
		begin
			a = (v + (ZW+1)'(256)) >>> 9;
			if (a > (ZW+1)'(LIMIT))
				rnd_sat = AW'(LIMIT);
			else if (a < -(ZW+1)'(LIMIT))
				rnd_sat = -AW'(LIMIT);
			else
				rnd_sat = a[AW-1:0];
		end
	endfunction
endpackage
`default_nettype wire

FILE: hdl/cpga_point_if.sv
// Input channel: one target point in camera coordinates
`default_nettype none
interface cpga_point_if;
	import cpga_pkg::*;
	logic valid;
	logic ready;
	logic signed [CW-1:0] cam_x;
	logic signed [CW-1:0] cam_y;
	logic signed [CW-1:0] cam_z;
	modport source(output valid, cam_x, cam_y, cam_z, input ready);
	modport sink(input valid, cam_x, cam_y, cam_z, output ready);
endinterface
`default_nettype wire

FILE: hdl/cpga_angle_if.sv
// Output channel: range and error flags with pitch and yaw
`default_nettype none
interface cpga_angle_if;
	import cpga_pkg::*;
	logic valid;
	logic ready;
	logic in_range;
	logic aim_error;
	logic signed [AW-1:0] pitch_deg;
	logic signed [AW-1:0] yaw_deg;
	modport source(output valid, in_range, aim_error, pitch_deg, yaw_deg, input ready);
	modport sink(input valid, in_range, aim_error, pitch_deg, yaw_deg, output ready);
endinterface
`default_nettype wire

FILE: hdl/cpga_isqrt_cell.sv
// One digit cell of the pipelined integer square root
`default_nettype none
module cpga_isqrt_cell
	import cpga_pkg::*;
#(
	parameter int STEP = 0
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [RW-1:0] rem_i,
	input  wire logic [RW-1:0] res_i,
	output logic      [RW-1:0] rem_o,
	output logic      [RW-1:0] res_o
);
	localparam logic [RW-1:0] BIT = RW'(1) << (RW - 2 - 2 * STEP);
	logic [RW-1:0] trial;

	assign trial = res_i + BIT;

	always_ff @(posedge clk) begin
		if (en) begin
			if (rem_i >= trial) begin
				rem_o <= rem_i - trial;
				res_o <= (res_i >> 1) + BIT;
			end else begin
				rem_o <= rem_i;
				res_o <= res_i >> 1;
			end
		end
	end
endmodule
`default_nettype wire

FILE: hdl/cpga_cordic_cell.sv
// One vectoring CORDIC stage cell
`default_nettype none
module cpga_cordic_cell
	import cpga_pkg::*;
#(
	parameter int STAGE = 0
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [KW-1:0] x_i,
	input  wire logic signed [KW-1:0] y_i,
	input  wire logic signed [ZW-1:0] z_i,
	output logic signed      [KW-1:0] x_o,
	output logic signed      [KW-1:0] y_o,
	output logic signed      [ZW-1:0] z_o
);
	logic signed [KW-1:0] xs;
	logic signed [KW-1:0] ys;

	assign xs = x_i >>> STAGE;
	assign ys = y_i >>> STAGE;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_i[KW-1]) begin
				x_o <= x_i + ys;
				y_o <= y_i - xs;
				z_o <= z_i + ATAN_TAB[STAGE];
			end else begin
				x_o <= x_i - ys;
				y_o <= y_i + xs;
				z_o <= z_i - ATAN_TAB[STAGE];
			end
		end
	end
endmodule
`default_nettype wire

FILE: hdl/camera_point_to_gimbal_angles.sv
// Top level: camera point to gimbal pitch and yaw, fully pipelined
// Takes one point per cycle whenever the output is free or taken in the same cycle.
// In order, the pipeline has registers for rotation, squares and range
// checks, a row of 30 square-root digit cells, CORDIC_STAGES rows of three CORDIC
// cells (yaw, line-of-sight pitch, barrel correction) and one rounding register.
// The whole row advances together; a stalled output holds every stage.
`default_nettype none
module camera_point_to_gimbal_angles
	import cpga_pkg::*;
#(
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	cpga_point_if.sink            pnt,
	cpga_angle_if.source          ang
);
	logic [47:0] rot_x_q, rot_y_q, rot_z_q;
	logic [59:0] trans_q;
	logic signed [23:0] barrel_q;
	logic [22:0] min_d_q, max_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_x_q <= '0;
			rot_y_q <= '0;
			rot_z_q <= '0;
			trans_q <= '0;
			barrel_q <= '0;
			min_d_q <= '0;
			max_d_q <= 23'h7FFFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROT_X: rot_x_q <= cfg_data[47:0];
				REG_ROT_Y: rot_y_q <= cfg_data[47:0];
				REG_ROT_Z: rot_z_q <= cfg_data[47:0];
				REG_TRANS: trans_q <= cfg_data[59:0];
				REG_BARREL: barrel_q <= cfg_data[23:0];
				REG_MIN_D: min_d_q <= cfg_data[22:0];
				REG_MAX_D: max_d_q <= cfg_data[22:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic vld_out_q;
	assign en = !vld_out_q || ang.ready;
	assign pnt.ready = en;

	logic [47:0] rows [0:2];
	logic signed [CW-1:0] cam [0:2];
	assign rows[0] = rot_x_q;
	assign rows[1] = rot_y_q;
	assign rows[2] = rot_z_q;
	assign cam[0] = pnt.cam_x;
	assign cam[1] = pnt.cam_y;
	assign cam[2] = pnt.cam_z;

	logic signed [39:0] prod_s1 [0:2][0:2];
	flag_t fl_s1, fl_s2, fl_s3, fl_s4;
	logic in_win;
	assign in_win = (pnt.cam_z >= $signed({1'b0, min_d_q}))
		&& (pnt.cam_z <= $signed({1'b0, max_d_q}));

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s1[r][j] <= $signed(rows[r][16*j +: 16]) * cam[j];
				end
			end
		end
	end

	logic signed [GW-1:0] g_s2 [0:2];
	logic signed [41:0] sum [0:2];
	logic signed [GW-1:0] tr [0:2];
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum[r] = 42'(prod_s1[r][0]) + 42'(prod_s1[r][1]) + 42'(prod_s1[r][2]);
			tr[r] = GW'($signed({trans_q[20*r +: 20], 4'b0}));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				g_s2[r] <= GW'($signed(sum[r][41:14])) - tr[r];
			end
		end
	end

	logic signed [GW-1:0] g_s3 [0:2];
	logic signed [2*GW-1:0] gy2_s3, gz2_s3;
	logic signed [47:0] b2_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			g_s3 <= g_s2;
			gy2_s3 <= g_s2[1] * g_s2[1];
			gz2_s3 <= g_s2[2] * g_s2[2];
			b2_s3 <= barrel_q * barrel_q;
		end
	end

	logic [RW-1:0] d2;
	logic err;
	assign d2 = RW'(gy2_s3[58:0]) + RW'(gz2_s3[58:0]);
	assign err = g_s3[2][GW-1] || (g_s3[2] == '0) || (RW'(b2_s3[46:0]) > d2);

	logic signed [GW-1:0] g_s4 [0:2];
	logic [RW-1:0] rad_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			g_s4 <= g_s3;
			rad_s4 <= d2 - RW'(b2_s3[46:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_s1 <= '0;
			fl_s2 <= '0;
			fl_s3 <= '0;
			fl_s4 <= '0;
		end else if (en) begin
			fl_s1 <= '{vld: pnt.valid, in_range: in_win, err: 1'b0};
			fl_s2 <= fl_s1;
			fl_s3 <= fl_s2;
			fl_s4 <= '{vld: fl_s3.vld, in_range: fl_s3.in_range, err: err};
		end
	end

	logic [RW-1:0] rem_w [0:SQ_STEPS];
	logic [RW-1:0] res_w [0:SQ_STEPS];
	side_t sd_q [0:SQ_STEPS];
	assign rem_w[0] = rad_s4;
	assign res_w[0] = '0;

	always_comb begin
		sd_q[0] = '{fl: fl_s4, gx: g_s4[0], gy: g_s4[1], gz: g_s4[2]};
	end

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
		cpga_isqrt_cell #(.STEP(k)) u_cell (
			.clk(clk), .en(en),
			.rem_i(rem_w[k]), .res_i(res_w[k]),
			.rem_o(rem_w[k+1]), .res_o(res_w[k+1])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sd_q[k+1] <= '0;
			end else if (en) begin
				sd_q[k+1] <= sd_q[k];
			end
		end
	end

	logic signed [KW-1:0] xa [0:CORDIC_STAGES][0:2];
	logic signed [KW-1:0] ya [0:CORDIC_STAGES][0:2];
	logic signed [ZW-1:0] za [0:CORDIC_STAGES][0:2];
	flag_t cf_q [0:CORDIC_STAGES];
	side_t sd_e;
	logic [SQW-1:0] root;
	assign sd_e = sd_q[SQ_STEPS];
	assign root = res_w[SQ_STEPS][SQW-1:0];

	assign xa[0][0] = {{(KW-GW-24){sd_e.gz[GW-1]}}, sd_e.gz, 24'b0};
	assign ya[0][0] = {{(KW-GW-24){sd_e.gx[GW-1]}}, sd_e.gx, 24'b0};
	assign xa[0][1] = {{(KW-GW-24){sd_e.gz[GW-1]}}, sd_e.gz, 24'b0};
	assign ya[0][1] = {{(KW-GW-24){sd_e.gy[GW-1]}}, sd_e.gy, 24'b0};
	assign xa[0][2] = {{(KW-SQW-24){1'b0}}, root, 24'b0};
	assign ya[0][2] = {{(KW-48){barrel_q[23]}}, barrel_q, 24'b0};
	assign za[0][0] = '0;
	assign za[0][1] = '0;
	assign za[0][2] = '0;

	always_comb begin
		cf_q[0] = sd_e.fl;
	end

	for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cd
		for (genvar u = 0; u < 3; u++) begin : g_u
			cpga_cordic_cell #(.STAGE(s)) u_cell (
				.clk(clk), .en(en),
				.x_i(xa[s][u]), .y_i(ya[s][u]), .z_i(za[s][u]),
				.x_o(xa[s+1][u]), .y_o(ya[s+1][u]), .z_o(za[s+1][u])
			);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cf_q[s+1] <= '0;
			end else if (en) begin
				cf_q[s+1] <= cf_q[s];
			end
		end
	end

	flag_t cl;
	logic signed [ZW:0] pitch_full;
	assign cl = cf_q[CORDIC_STAGES];
	assign pitch_full = (ZW+1)'(za[CORDIC_STAGES][1]) - (ZW+1)'(za[CORDIC_STAGES][2]);

	logic in_range_q, aim_error_q;
	logic signed [AW-1:0] pitch_q, yaw_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_q <= 1'b0;
		end else if (en) begin
			vld_out_q <= cl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_range_q <= cl.in_range;
			aim_error_q <= cl.in_range && cl.err;
			if (cl.in_range && !cl.err) begin
				pitch_q <= rnd_sat(pitch_full);
				yaw_q <= rnd_sat((ZW+1)'(za[CORDIC_STAGES][0]));
			end else begin
				pitch_q <= '0;
				yaw_q <= '0;
			end
		end
	end

	assign ang.valid = vld_out_q;
	assign ang.in_range = in_range_q;
	assign ang.aim_error = aim_error_q;
	assign ang.pitch_deg = pitch_q;
	assign ang.yaw_deg = yaw_q;

	a_err_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ang.valid && ang.aim_error |-> ang.in_range)
		else $error("aim error without range");
	a_out_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ang.valid && (!ang.in_range || ang.aim_error) |->
		ang.pitch_deg == '0 && ang.yaw_deg == '0)
		else $error("angles not cleared");
	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		ang.valid |-> ang.pitch_deg <= AW'(LIMIT) && ang.pitch_deg >= -AW'(LIMIT)
		&& ang.yaw_deg <= AW'(LIMIT) && ang.yaw_deg >= -AW'(LIMIT))
		else $error("angle beyond limit");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pnt.ready == (!ang.valid || ang.ready))
		else $error("ready does not follow output");
endmodule
`default_nettype wire
